### src/ghp_pkg.sv
// Shared types, constants and exp table function for the gaussian heatmap pixel block.
`timescale 1ns / 1ps

package ghp_pkg;

  localparam int unsigned DimW   = 11;
  localparam int unsigned CoordW = 10;
  localparam int unsigned PointW = 12;
  localparam int unsigned MapW   = 5;
  localparam int unsigned AddrW  = 25;
  localparam int unsigned ValW   = 17;
  localparam int unsigned SigmaW = 24;
  localparam int unsigned DistW  = 25;
  localparam int unsigned ProdW  = DistW + SigmaW;
  localparam int unsigned FracW  = 20;
  localparam int unsigned InW    = 56;
  localparam int unsigned OutW   = 48;
  localparam int unsigned CfgW   = 24;

  localparam logic [DimW-1:0]  MaxDim  = 11'd1024;
  localparam logic [MapW:0]    MaxMaps = 6'd32;

  localparam logic [DimW-1:0]   RstWidth     = 11'd64;
  localparam logic [DimW-1:0]   RstHeight    = 11'd64;
  localparam logic [SigmaW-1:0] RstInvSigma  = 24'd669;
  localparam logic [ValW-1:0]   RstThreshold = 17'd0;
  localparam logic [2*DimW-1:0] RstPlane     = 22'd4096;

  typedef enum logic [1:0] {
    CfgWidth     = 2'd0,
    CfgHeight    = 2'd1,
    CfgInvSigma  = 2'd2,
    CfgThreshold = 2'd3
  } cfg_reg_e;

  // exp(-k * 16 / 2^bits) in Q1.16: Taylor series of e^(-x/256) in Q0.31, squared eight times
  function automatic logic [ValW-1:0] exp_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = 64'(k) << (27 - bits);
    term = 64'h8000_0000;
    sum  = term;
    term = (term * y) >> 31;
    sum  = sum - term;
    term = ((term * y) >> 31) / 2;
    sum  = sum + term;
    term = ((term * y) >> 31) / 3;
    sum  = sum - term;
    term = ((term * y) >> 31) / 4;
    sum  = sum + term;
    term = ((term * y) >> 31) / 5;
    sum  = sum - term;
    term = ((term * y) >> 31) / 6;
    sum  = sum + term;
    for (int i = 0; i < 8; i++) begin
      sum = (sum * sum + 64'h4000_0000) >> 31;
    end
    return ValW'((sum + 64'h4000) >> 15);
  endfunction

endpackage

### src/gaussian_heatmap_pixel.sv
// Gaussian heatmap pixel renderer: squared distance, scale, exp table, address and write enable.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  map, pixel x/y, keypoint x/y
//   m_axis    out        m_axis_tvalid / m_axis_tready  map, address, value, write enable
//   cfg       in         cfg_valid_i / cfg_ready_o      register index, write data
//
// Six register stages; one item per cycle while the output is not stalled.
// Stage 4 holds the 25x24 exponent multiply; the exp table read has a stage of its own.
// Reset clears all valid bits and loads width 64, height 64, scale 669, threshold 0.
// Each stage has its own ready, so a stalled output only blocks once the stages behind it fill.
`timescale 1ns / 1ps

module gaussian_heatmap_pixel
  import ghp_pkg::*;
#(
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] map_index, [14:5] pixel_x, [24:15] pixel_y, [36:25] point_x, [48:37] point_y
  input  logic [InW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [4:0] map_out, [29:5] address, [46:30] value, [47] write_enable
  output logic [OutW-1:0]  m_axis_tdata,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i
);

  localparam int unsigned TableDepth = 1 << EXP_TABLE_BITS;

  // configuration
  logic [DimW-1:0]   width_q, height_q;
  logic [SigmaW-1:0] inv_q;
  logic [ValW-1:0]   thr_q;
  logic [2*DimW-1:0] plane_q, plane_d;
  logic [DimW-1:0]   wc, hc;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    wc      = (width_q > MaxDim) ? MaxDim : width_q;
    hc      = (height_q > MaxDim) ? MaxDim : height_q;
    plane_d = wc * hc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RstWidth;
      height_q <= RstHeight;
      inv_q    <= RstInvSigma;
      thr_q    <= RstThreshold;
      plane_q  <= RstPlane;
    end else begin
      plane_q <= plane_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CfgWidth:     width_q  <= cfg_data_i[DimW-1:0];
          CfgHeight:    height_q <= cfg_data_i[DimW-1:0];
          CfgInvSigma:  inv_q    <= cfg_data_i[SigmaW-1:0];
          CfgThreshold: thr_q    <= cfg_data_i[ValW-1:0];
          default:      ;
        endcase
      end
    end
  end

  // exp table
  logic [ValW-1:0] exp_rom [TableDepth];

  for (genvar k = 0; k < TableDepth; k++) begin : g_rom
    localparam logic [ValW-1:0] Entry = exp_entry(k, EXP_TABLE_BITS);
    assign exp_rom[k] = Entry;
  end

  // handshake chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6          = ~v6_q | m_axis_tready;
  assign rdy5          = ~v5_q | rdy6;
  assign rdy4          = ~v4_q | rdy5;
  assign rdy3          = ~v3_q | rdy4;
  assign rdy2          = ~v2_q | rdy3;
  assign rdy1          = ~v1_q | rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // stage 1: unpack, coordinate differences
  logic [MapW-1:0]          in_map;
  logic [CoordW-1:0]        in_px, in_py;
  logic [PointW-1:0]        in_qx, in_qy;
  logic signed [PointW:0]   dx1_d, dy1_d, dx1_q, dy1_q;
  logic [MapW-1:0]          map1_q;
  logic [CoordW-1:0]        px1_q, py1_q;

  always_comb begin
    in_map = s_axis_tdata[4:0];
    in_px  = s_axis_tdata[14:5];
    in_py  = s_axis_tdata[24:15];
    in_qx  = s_axis_tdata[36:25];
    in_qy  = s_axis_tdata[48:37];
    dx1_d  = $signed({3'b000, in_px}) - $signed({in_qx[PointW-1], in_qx});
    dy1_d  = $signed({3'b000, in_py}) - $signed({in_qy[PointW-1], in_qy});
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      map1_q <= in_map;
      px1_q  <= in_px;
      py1_q  <= in_py;
    end
  end

  // stage 2: squares, row offset, bounds
  logic signed [2*PointW+1:0] sqx_w, sqy_w;
  logic [DistW-2:0]           sqx2_q, sqy2_q;
  logic [CoordW+DimW-1:0]     pyw2_d, pyw2_q;
  logic                       inb2_d, inb2_q;
  logic [MapW-1:0]            map2_q;
  logic [CoordW-1:0]          px2_q;

  always_comb begin
    sqx_w  = dx1_q * dx1_q;
    sqy_w  = dy1_q * dy1_q;
    pyw2_d = py1_q * wc;
    inb2_d = ({1'b0, px1_q} < wc) && ({1'b0, py1_q} < hc) && ({1'b0, map1_q} < MaxMaps);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sqx2_q <= sqx_w[DistW-2:0];
      sqy2_q <= sqy_w[DistW-2:0];
      pyw2_q <= pyw2_d;
      inb2_q <= inb2_d;
      map2_q <= map1_q;
      px2_q  <= px1_q;
    end
  end

  // stage 3: distance, plane offset, in-plane offset
  logic [DistW-1:0]           dist3_d, dist3_q;
  logic [MapW+2*DimW-1:0]     mhw_w;
  logic [AddrW-1:0]           mhw3_q;
  logic [CoordW+DimW-1:0]     lo3_d, lo3_q;
  logic                       inb3_q;
  logic [MapW-1:0]            map3_q;

  always_comb begin
    dist3_d = {1'b0, sqx2_q} + {1'b0, sqy2_q};
    mhw_w   = map2_q * plane_q;
    lo3_d   = pyw2_q + (CoordW+DimW)'(px2_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      dist3_q <= dist3_d;
      mhw3_q  <= mhw_w[AddrW-1:0];
      lo3_q   <= lo3_d;
      inb3_q  <= inb2_q;
      map3_q  <= map2_q;
    end
  end

  // stage 4: exponent, address
  logic [ProdW-1:0]          a_w;
  logic [AddrW-1:0]          addr4_d, addr4_q;
  logic                      big4_q;
  logic [EXP_TABLE_BITS-1:0] idx4_q;
  logic                      inb4_q;
  logic [MapW-1:0]           map4_q;

  always_comb begin
    a_w     = dist3_q * inv_q;
    addr4_d = mhw3_q + AddrW'(lo3_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      big4_q  <= |a_w[ProdW-1:FracW];
      idx4_q  <= a_w[FracW-1 -: EXP_TABLE_BITS];
      addr4_q <= addr4_d;
      inb4_q  <= inb3_q;
      map4_q  <= map3_q;
    end
  end

  // stage 5: table read
  logic [ValW-1:0]  val5_q;
  logic [AddrW-1:0] addr5_q;
  logic             inb5_q;
  logic [MapW-1:0]  map5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      val5_q  <= big4_q ? '0 : exp_rom[idx4_q];
      addr5_q <= addr4_q;
      inb5_q  <= inb4_q;
      map5_q  <= map4_q;
    end
  end

  // stage 6: threshold, output register
  logic [ValW-1:0]  val6_q;
  logic [AddrW-1:0] addr6_q;
  logic             we6_q;
  logic [MapW-1:0]  map6_q;

  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      val6_q  <= val5_q;
      addr6_q <= addr5_q;
      we6_q   <= inb5_q && (val5_q > thr_q);
      map6_q  <= map5_q;
    end
  end

  assign m_axis_tdata = {we6_q, val6_q, addr6_q, map6_q};

  // checks
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> val6_q <= 17'h10000)
    else $error("value above one");

  a_big_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && rdy5 && big4_q |=> val5_q == '0)
    else $error("large exponent did not give zero");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && v6_q && !m_axis_tready |=> v5_q && v6_q)
    else $error("item lost in stall");

  a_out_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && rdy6 && !inb5_q |=> !we6_q)
    else $error("write enabled outside plane");

endmodule

### tb/tb_gaussian_heatmap_pixel.sv
// Testbench for gaussian_heatmap_pixel: directed and random pixels, phased configs, scoreboard check.
`timescale 1ns / 1ps

module tb_gaussian_heatmap_pixel
  import ghp_pkg::*;
;

  localparam int unsigned TableBits = 10;
  localparam int unsigned TableSize = 1 << TableBits;

  // same layout as m_axis_tdata: map lowest, write enable on top
  typedef struct packed {
    logic            we;
    logic [ValW-1:0]  value;
    logic [AddrW-1:0] addr;
    logic [MapW-1:0]  map;
  } heat_result_t;

  class pixel_checker;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [SigmaW-1:0] inv_sigma;
    logic [ValW-1:0]   thresh;
    logic [ValW-1:0]   exp_rom [TableSize];
    heat_result_t      due [$];
    int                errors;

    function new();
      width     = RstWidth;
      height    = RstHeight;
      inv_sigma = RstInvSigma;
      thresh    = RstThreshold;
      errors    = 0;
      for (int k = 0; k < TableSize; k++) begin
        exp_rom[k] = exp_rom_entry(k);
      end
    endfunction

    // e^(-x/256) by series to the sixth power in Q0.31, squared eight times, rounded to Q1.16
    function logic [ValW-1:0] exp_rom_entry(int unsigned k);
      longint unsigned y;
      longint unsigned term;
      longint unsigned acc;
      y    = longint'(k) << (27 - TableBits);
      term = 64'h8000_0000;
      acc  = term;
      for (longint unsigned n = 1; n <= 6; n++) begin
        term = ((term * y) >> 31) / n;
        if (n[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      for (int i = 0; i < 8; i++) begin
        acc = (acc * acc + 64'h4000_0000) >> 31;
      end
      return ValW'((acc + 64'h4000) >> 15);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("%0t ERROR %s: got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    function void set_reg(cfg_reg_e idx, logic [CfgW-1:0] v);
      case (idx)
        CfgWidth:     width = v[DimW-1:0];
        CfgHeight:    height = v[DimW-1:0];
        CfgInvSigma:  inv_sigma = v[SigmaW-1:0];
        CfgThreshold: thresh = v[ValW-1:0];
        default: ;
      endcase
    endfunction

    function heat_result_t render(logic [InW-1:0] d);
      heat_result_t      r;
      logic [9:0]        px;
      logic [9:0]        py;
      logic signed [11:0] ptx;
      logic signed [11:0] pty;
      int                dx;
      int                dy;
      longint unsigned   sq_dist;
      longint unsigned   expo;
      longint unsigned   w;
      longint unsigned   h;
      px   = d[14:5];
      py   = d[24:15];
      ptx  = d[36:25];
      pty  = d[48:37];
      dx   = int'(px) - int'(ptx);
      dy   = int'(py) - int'(pty);
      sq_dist = longint'(dx * dx + dy * dy);
      expo = sq_dist * inv_sigma;
      w    = (width > MaxDim) ? MaxDim : width;
      h    = (height > MaxDim) ? MaxDim : height;
      r.map   = d[4:0];
      r.value = (expo >= (64'd1 << 20)) ? '0 : exp_rom[expo >> (20 - TableBits)];
      r.addr  = AddrW'(longint'(r.map) * h * w + longint'(py) * w + px);
      r.we    = (r.value > thresh) && (px < w) && (py < h) && (r.map < MaxMaps);
      return r;
    endfunction

    function void accept_pixel(logic [InW-1:0] d);
      due = {due, render(d)};
    endfunction

    task check_result(logic [OutW-1:0] d);
      heat_result_t got;
      heat_result_t want;
      got = d;
      if (due.size() == 0) begin
        report("unexpected item, address", got.addr, 0);
        return;
      end
      want = due.pop_front();
      if (got.map != want.map) report("map_out", got.map, want.map);
      if (got.addr != want.addr) report("address", got.addr, want.addr);
      if (got.value != want.value) report("value", got.value, want.value);
      if (got.we != want.we) report("write_enable", got.we, want.we);
    endtask

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  pixel_checker sb = new();

  // per-phase register settings
  int unsigned ph_width [8]  = '{64, 1, 1024, 2047, 0, 100, 640, 1024};
  int unsigned ph_height [8] = '{64, 1, 1024, 2047, 0, 37, 480, 1};
  int unsigned ph_sigma [8]  = '{669, 0, 16777215, 65536, 1000, 3000, 200, 40000};
  int unsigned ph_thresh [8] = '{0, 0, 65535, 65536, 131071, 30000, 100, 65535};
  int unsigned ph_src [4]    = '{0, 75, 0, 36};
  int unsigned ph_sink [4]   = '{0, 0, 75, 36};

  gaussian_heatmap_pixel #(
    .EXP_TABLE_BITS(TableBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  function automatic logic [InW-1:0] pack_pixel(int map, int px, int py, int ptx, int pty);
    return {7'd0, 12'(pty), 12'(ptx), 10'(py), 10'(px), 5'(map)};
  endfunction

  // mostly keypoints near an in-plane pixel, some far, some anywhere
  function automatic logic [InW-1:0] rand_pixel(int unsigned wl, int unsigned hl);
    int unsigned sel;
    int unsigned span;
    int          px;
    int          py;
    int          ptx;
    int          pty;
    sel = $urandom_range(99);
    px  = $urandom_range(1023);
    py  = $urandom_range(1023);
    ptx = $urandom_range(4095);
    pty = $urandom_range(4095);
    if (sel < 80) begin
      px = $urandom_range(wl - 1);
      py = $urandom_range(hl - 1);
    end
    if (sel < 65) begin
      case ($urandom_range(3))
        0: span = 0;
        1: span = 4;
        2: span = 40;
        default: span = 1100;
      endcase
      ptx = px + int'($urandom_range(2 * span)) - int'(span);
      pty = py + int'($urandom_range(2 * span)) - int'(span);
    end
    return pack_pixel($urandom_range(31), px, py, ptx, pty);
  endfunction

  task automatic send_pixel(logic [InW-1:0] d);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.accept_pixel(d);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(int unsigned w, int unsigned h, int unsigned s, int unsigned t);
    wait_drained();
    write_reg(CfgWidth, CfgW'(w));
    write_reg(CfgHeight, CfgW'(h));
    write_reg(CfgInvSigma, CfgW'(s));
    write_reg(CfgThreshold, CfgW'(t));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned wl;
    int unsigned hl;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: plane edges, coordinate extremes, exponent near the table end
    send_pixel(pack_pixel(0, 0, 0, 0, 0));
    send_pixel(pack_pixel(31, 63, 63, 63, 63));
    send_pixel(pack_pixel(5, 64, 10, 64, 10));
    send_pixel(pack_pixel(7, 10, 64, 10, 64));
    send_pixel(pack_pixel(31, 1023, 1023, 2047, 2047));
    send_pixel(pack_pixel(0, 0, 0, -2048, -2048));
    send_pixel(pack_pixel(16, 1023, 0, -1024, 1023));
    send_pixel(pack_pixel(3, 20, 20, 25, 22));
    send_pixel(pack_pixel(9, 0, 0, 39, 0));
    send_pixel(pack_pixel(9, 0, 0, 40, 0));

    // scale 1.0: exponent exactly 16 gives zero
    apply_config(64, 64, 65536, 65535);
    send_pixel(pack_pixel(1, 5, 5, 5, 5));
    send_pixel(pack_pixel(2, 5, 5, 8, 7));
    send_pixel(pack_pixel(3, 5, 5, 9, 5));
    send_pixel(pack_pixel(4, 5, 5, 6, 5));

    // threshold of one: nothing exceeds it
    apply_config(64, 64, 65536, 65536);
    send_pixel(pack_pixel(1, 5, 5, 5, 5));
    send_pixel(pack_pixel(2, 30, 40, 30, 41));

    for (int ph = 0; ph < 8; ph++) begin
      apply_config(ph_width[ph], ph_height[ph], ph_sigma[ph], ph_thresh[ph]);
      src_idle   = ph_src[ph % 4];
      sink_stall = ph_sink[ph % 4];
      wl = (ph_width[ph] == 0 || ph_width[ph] > 1024) ? 1024 : ph_width[ph];
      hl = (ph_height[ph] == 0 || ph_height[ph] > 1024) ? 1024 : ph_height[ph];
      for (int n = 0; n < 182; n++) begin
        send_pixel(rand_pixel(wl, hl));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.outstanding() != 0) sb.report("items never returned", sb.outstanding(), 0);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
